### src/w2u8_pkg.sv
// Shared types, error codes and the UTF-8 byte encoder for the wide-to-UTF-8 transcoder.
// Used by w2u8_front, w2u8_queue, w2u8_back and wide_to_utf8_transcoder_core.
package w2u8_pkg;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_DANGLING  = 3'd1,
		ERR_BAD_LOW   = 3'd2,
		ERR_LONE_LOW  = 3'd3,
		ERR_SURROGATE = 3'd4,
		ERR_RANGE     = 3'd5
	} err_t;

	localparam logic FMT_UTF16 = 1'b0;
	localparam logic FMT_UTF32 = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_IDX_FORMAT = 1'b0;

	// One queued job: up to four bytes, index of its final byte, error code, string end.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		err_t            err;
		logic            eos;
	} job_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
	} enc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// cp must be a valid scalar value
	function automatic enc_t encode(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp <= 21'h7F) begin
			e.bytes[0] = {1'b0, cp[6:0]};
			e.last_idx = 2'd0;
		end else if (cp <= 21'h7FF) begin
			e.bytes[0] = {3'b110, cp[10:6]};
			e.bytes[1] = {2'b10, cp[5:0]};
			e.last_idx = 2'd1;
		end else if (cp <= 21'hFFFF) begin
			e.bytes[0] = {4'b1110, cp[15:12]};
			e.bytes[1] = {2'b10, cp[11:6]};
			e.bytes[2] = {2'b10, cp[5:0]};
			e.last_idx = 2'd2;
		end else begin
			e.bytes[0] = {5'b11110, cp[20:18]};
			e.bytes[1] = {2'b10, cp[17:12]};
			e.bytes[2] = {2'b10, cp[11:6]};
			e.bytes[3] = {2'b10, cp[5:0]};
			e.last_idx = 2'd3;
		end
		return e;
	endfunction

endpackage

### src/w2u8_front.sv
// Front end: classifies each accepted code unit, tracks surrogate and error state,
// and builds a byte job for the queue. Depends on w2u8_pkg.
module w2u8_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fmt,
	input  logic              accept,
	input  logic [31:0]       code_unit,
	input  logic              end_of_string,
	output logic              push,
	output w2u8_pkg::job_t    job
);

	logic [9:0]          held_high_bits_q;
	logic                high_pending_q;
	logic                string_failed_q;
	logic [9:0]          held_d;
	logic                pending_d;
	logic                failed_d;
	logic                has_result;
	logic                is_err;
	w2u8_pkg::err_t      err_code;
	logic [15:0]         u16;
	logic                is_hi;
	logic                is_lo;
	logic                is_surr32;
	w2u8_pkg::enc_t      enc;

	assign u16       = code_unit[15:0];
	assign is_hi     = (u16[15:10] == 6'b110110);
	assign is_lo     = (u16[15:10] == 6'b110111);
	assign is_surr32 = (code_unit[31:16] == 16'h0000) && (u16[15:11] == 5'b11011);

	always_comb begin
		held_d     = held_high_bits_q;
		pending_d  = high_pending_q;
		failed_d   = string_failed_q;
		has_result = 1'b0;
		is_err     = 1'b0;
		err_code   = w2u8_pkg::ERR_NONE;
		enc        = '0;
		if (string_failed_q) begin
			// skip the rest of the string
			if (end_of_string) begin
				failed_d  = 1'b0;
				pending_d = 1'b0;
				held_d    = '0;
			end
		end else if (fmt == w2u8_pkg::FMT_UTF32) begin
			pending_d = 1'b0;
			held_d    = '0;
			if (is_surr32) begin
				is_err   = 1'b1;
				err_code = w2u8_pkg::ERR_SURROGATE;
			end else if (code_unit > 32'h0010FFFF) begin
				is_err   = 1'b1;
				err_code = w2u8_pkg::ERR_RANGE;
			end else begin
				enc        = w2u8_pkg::encode(code_unit[20:0]);
				has_result = 1'b1;
			end
		end else if (high_pending_q) begin
			if (is_lo) begin
				enc        = w2u8_pkg::encode(21'h10000 + {1'b0, held_high_bits_q, u16[9:0]});
				has_result = 1'b1;
				pending_d  = 1'b0;
				held_d     = '0;
			end else begin
				is_err   = 1'b1;
				err_code = w2u8_pkg::ERR_BAD_LOW;
			end
		end else if (is_hi) begin
			if (end_of_string) begin
				is_err   = 1'b1;
				err_code = w2u8_pkg::ERR_DANGLING;
			end else begin
				held_d    = u16[9:0];
				pending_d = 1'b1;
			end
		end else if (is_lo) begin
			is_err   = 1'b1;
			err_code = w2u8_pkg::ERR_LONE_LOW;
		end else begin
			enc        = w2u8_pkg::encode({5'b00000, u16});
			has_result = 1'b1;
		end

		if (is_err) begin
			has_result = 1'b1;
			enc        = '0;
			pending_d  = 1'b0;
			held_d     = '0;
			failed_d   = !end_of_string;
		end

		job.bytes    = enc.bytes;
		job.last_idx = enc.last_idx;
		job.err      = err_code;
		job.eos      = end_of_string;
		push         = accept && has_result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_high_bits_q <= '0;
			high_pending_q   <= 1'b0;
			string_failed_q  <= 1'b0;
		end else if (accept) begin
			held_high_bits_q <= held_d;
			high_pending_q   <= pending_d;
			string_failed_q  <= failed_d;
		end
	end

endmodule

### src/w2u8_queue.sv
// Short job queue between the classifying front end and the byte serializer.
// Depends on w2u8_pkg for the job and status types.
module w2u8_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  w2u8_pkg::job_t     push_job,
	input  logic               pop,
	output w2u8_pkg::job_t     head_job,
	output w2u8_pkg::q_stat_t  stat
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	w2u8_pkg::job_t  mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### src/w2u8_back.sv
// Back end: walks the job at the queue head and sends one byte per beat
// through an output register. Depends on w2u8_pkg.
module w2u8_back (
	input  logic               clk,
	input  logic               arst_n,
	input  w2u8_pkg::job_t     head_job,
	input  logic               q_empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic [2:0]         error,
	output logic               last_of_run,
	output logic               string_done
);

	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [2:0]  error_q;
	logic        last_q;
	logic        done_q;
	logic        load;
	logic        emit;
	logic        is_last;

	assign load    = !out_valid_q || !out_stall;
	assign emit    = load && !q_empty;
	assign is_last = (idx_q == head_job.last_idx);
	assign pop     = emit && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= !q_empty;
			end
			if (emit) begin
				idx_q <= is_last ? 2'd0 : idx_q + 1'b1;
			end
		end
	end

	// payload holds while the beat is stalled
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= head_job.bytes[idx_q];
			error_q    <= head_job.err;
			last_q     <= is_last;
			done_q     <= is_last && head_job.eos;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign error       = error_q;
	assign last_of_run = last_q;
	assign string_done = done_q;

endmodule

### src/wide_to_utf8_transcoder_core.sv
// UTF-16LE / UTF-32 to UTF-8 transcoder: front classifier, job queue, byte serializer.
// The first byte of an item passes through the queue memory and the output register of the back end.
// Output: one byte per cycle while out_stall is low; an item gives 1 to 4 bytes (its UTF-8
// length); held high surrogates and skipped units emit nothing.
// Reset (arst_n low, asynchronous): queue empty, no beat pending, format UTF-16,
// surrogate and error-skip state cleared.
module wide_to_utf8_transcoder_core #(
	parameter int QDEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] code_unit,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [2:0]  error,
	output logic        last_of_run,
	output logic        string_done
);

	logic               format_q;
	logic               accept;
	logic               push;
	logic               pop;
	w2u8_pkg::job_t     front_job;
	w2u8_pkg::job_t     head_job;
	w2u8_pkg::q_stat_t  q_stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == w2u8_pkg::REG_IDX_FORMAT) ? {31'b0, format_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= w2u8_pkg::FMT_UTF16;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == w2u8_pkg::REG_IDX_FORMAT)) begin
			format_q <= pwdata[0];
		end
	end

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;

	w2u8_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.fmt           (format_q),
		.accept        (accept),
		.code_unit     (code_unit),
		.end_of_string (end_of_string),
		.push          (push),
		.job           (front_job)
	);

	w2u8_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (front_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (q_stat)
	);

	w2u8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_job    (head_job),
		.q_empty     (q_stat.empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.error       (error),
		.last_of_run (last_of_run),
		.string_done (string_done)
	);

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error != w2u8_pkg::ERR_NONE) |-> (out_byte == 8'h00) && last_of_run)
		else $error("error beat carries data or is not the last of its run");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_done |-> last_of_run)
		else $error("string end flagged before the last beat of a run");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue pushed while full");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for wide_to_utf8_transcoder_core: UTF-16LE / UTF-32 code units in,
// UTF-8 beats out, each beat matched against a scoreboard that decodes the units itself.
// Depends on w2u8_pkg for the error codes and the format constants.
module tb;

	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 4000;
	localparam int RANDOM_UNITS = 400;
	localparam int BATCH_UNITS  = 50;
	localparam logic [2:0] ADDR_FORMAT = 3'd0;
	localparam logic [2:0] ADDR_UNUSED = 3'd4;

	typedef struct {
		logic [7:0] octet;
		logic [2:0] err;
		logic       last;
		logic       done;
	} utf8_beat_t;

	class utf8_scoreboard;
		logic       fmt;
		logic [9:0] held_bits;
		logic       high_held;
		logic       skipping;
		utf8_beat_t pending_bytes[$];
		int         fails;

		function new();
			fmt = w2u8_pkg::FMT_UTF16;
			held_bits = '0;
			high_held = 1'b0;
			skipping = 1'b0;
			fails = 0;
		endfunction

		function void write_reg(int idx, logic [31:0] value);
			if (idx == int'(w2u8_pkg::REG_IDX_FORMAT)) fmt = value[0];
		endfunction

		function void add_beat(logic [7:0] octet, w2u8_pkg::err_t err, logic last,
				logic done);
			utf8_beat_t b;
			b.octet = octet;
			b.err = err;
			b.last = last;
			b.done = done;
			pending_bytes = {pending_bytes, b};
		endfunction

		// Report once, then drop the rest of the string unless this was its last unit.
		function void flag_error(w2u8_pkg::err_t code, logic eos);
			high_held = 1'b0;
			held_bits = '0;
			skipping = !eos;
			add_beat(8'h00, code, 1'b1, eos);
		endfunction

		function void encode_scalar(logic [20:0] cp, logic eos);
			logic [7:0] seq[4];
			int n;
			seq[1] = '0;
			seq[2] = '0;
			seq[3] = '0;
			if (cp < 21'h80) begin
				n = 1;
				seq[0] = {1'b0, cp[6:0]};
			end else if (cp < 21'h800) begin
				n = 2;
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
			end else if (cp < 21'h10000) begin
				n = 3;
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
			end else begin
				n = 4;
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
			end
			for (int i = 0; i < n; i++)
				add_beat(seq[i], w2u8_pkg::ERR_NONE, i == n - 1, (i == n - 1) && eos);
		endfunction

		// Returns 0 for a unit swallowed while skipping a failed string.
		function bit predict_bytes(logic [31:0] unit, logic eos);
			logic [15:0] half;
			logic [20:0] cp;
			if (skipping) begin
				if (eos) begin
					skipping = 1'b0;
					high_held = 1'b0;
					held_bits = '0;
				end
				return 1'b0;
			end
			if (fmt == w2u8_pkg::FMT_UTF32) begin
				high_held = 1'b0;
				held_bits = '0;
				if (unit >= 32'hD800 && unit <= 32'hDFFF)
					flag_error(w2u8_pkg::ERR_SURROGATE, eos);
				else if (unit > 32'h10FFFF)
					flag_error(w2u8_pkg::ERR_RANGE, eos);
				else
					encode_scalar(unit[20:0], eos);
				return 1'b1;
			end
			half = unit[15:0];
			if (high_held) begin
				if (half[15:10] != 6'b110111) begin
					flag_error(w2u8_pkg::ERR_BAD_LOW, eos);
				end else begin
					cp = 21'h10000 + {1'b0, held_bits, half[9:0]};
					high_held = 1'b0;
					held_bits = '0;
					encode_scalar(cp, eos);
				end
			end else if (half[15:10] == 6'b110110) begin
				if (eos) begin
					flag_error(w2u8_pkg::ERR_DANGLING, eos);
				end else begin
					held_bits = half[9:0];
					high_held = 1'b1;
				end
			end else if (half[15:10] == 6'b110111) begin
				flag_error(w2u8_pkg::ERR_LONE_LOW, eos);
			end else begin
				encode_scalar({5'b0, half}, eos);
			end
			return 1'b1;
		endfunction

		function void check_beat(logic [7:0] octet, logic [2:0] err, logic last, logic done);
			utf8_beat_t want;
			if (pending_bytes.size() == 0) begin
				$error("unexpected beat: out_byte %02h error %0d", octet, err);
				fails++;
				return;
			end
			want = pending_bytes.pop_front();
			if (octet !== want.octet) begin
				$error("out_byte: expected %02h, got %02h", want.octet, octet);
				fails++;
			end
			if (err !== want.err) begin
				$error("error: expected %0d, got %0d", want.err, err);
				fails++;
			end
			if (last !== want.last) begin
				$error("last_of_run: expected %0b, got %0b", want.last, last);
				fails++;
			end
			if (done !== want.done) begin
				$error("string_done: expected %0b, got %0b", want.done, done);
				fails++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] code_unit;
	logic        end_of_string;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic [2:0]  error;
	logic        last_of_run;
	logic        string_done;

	utf8_scoreboard sb = new();
	int live_units = 0;
	int quiet_cycles = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	bit hold_req = 1'b0;

	wide_to_utf8_transcoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_unit(code_unit),
		.end_of_string(end_of_string),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.error(error),
		.last_of_run(last_of_run),
		.string_done(string_done)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [20:0] pick_scalar();
		logic [20:0] cp;
		case ($urandom_range(0, 9))
			0, 1, 2: cp = 21'($urandom_range(0, 'h7F));
			3, 4:    cp = 21'($urandom_range('h80, 'h7FF));
			5, 6: begin
				cp = 21'($urandom_range('h800, 'hFFFF));
				// move surrogates up into E000..FFFF
				if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
			end
			7, 8:    cp = 21'($urandom_range('h10000, 'h10FFFF));
			default: begin
				case ($urandom_range(0, 9))
					0: cp = 21'h0;
					1: cp = 21'h7F;
					2: cp = 21'h80;
					3: cp = 21'h7FF;
					4: cp = 21'h800;
					5: cp = 21'hD7FF;
					6: cp = 21'hE000;
					7: cp = 21'hFFFF;
					8: cp = 21'h10000;
					default: cp = 21'h10FFFF;
				endcase
			end
		endcase
		return cp;
	endfunction

	function automatic logic [31:0] noise_unit();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 2))
			0: return r;
			1: return {(sb.fmt == w2u8_pkg::FMT_UTF16) ? r[31:16] : 16'h0000,
				5'b11011, r[10:0]};
			default: return $urandom_range(32'h0011_0000, 32'hFFFF_FFFF);
		endcase
	endfunction

	task automatic send_unit(logic [31:0] unit, logic eos);
		int gap;
		gap = tx_idle_en ? draw_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= unit;
		end_of_string <= eos;
		do @(posedge clk); while (in_stall);
		if (sb.predict_bytes(unit, eos)) live_units++;
	endtask

	// One string of well-formed code points, now and then with a damaged unit.
	task automatic send_string();
		logic [31:0] units[$];
		logic [20:0] cp;
		logic [19:0] off;
		logic [31:0] r;
		int n_cp;
		n_cp = $urandom_range(1, 5);
		r = $urandom();
		for (int i = 0; i < n_cp; i++) begin
			cp = pick_scalar();
			r = $urandom();
			if (sb.fmt == w2u8_pkg::FMT_UTF32) begin
				units = {units, {11'b0, cp}};
			end else if (cp < 21'h10000) begin
				units = {units,
					{($urandom_range(0, 3) == 0) ? r[31:16] : 16'h0000, cp[15:0]}};
			end else begin
				off = 20'(cp - 21'h10000);
				units = {units, {16'h0000, 6'b110110, off[19:10]}};
				units = {units, {16'h0000, 6'b110111, off[9:0]}};
			end
		end
		if ($urandom_range(0, 7) == 0)
			units[$urandom_range(0, units.size() - 1)] = noise_unit();
		// end the string on a high surrogate now and then
		if (sb.fmt == w2u8_pkg::FMT_UTF16 && $urandom_range(0, 15) == 0)
			units = {units, {16'h0000, 6'b110110, r[9:0]}};
		foreach (units[i])
			send_unit(units[i], i == units.size() - 1);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending_bytes.size() != 0) @(posedge clk);
		// let a held or skipped unit leave the front end
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(int'(addr[2]), data);
	endtask

	task automatic apb_read(logic [2:0] addr, output logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_format_reg();
		logic [31:0] rd;
		apb_read(ADDR_FORMAT, rd);
		if (rd !== {31'b0, sb.fmt}) begin
			$error("input_format readback: expected %0d, got %08h", sb.fmt, rd);
			sb.fails++;
		end
	endtask

	task automatic set_format(logic fmt);
		apb_write(ADDR_FORMAT, {31'b0, fmt});
		check_format_reg();
	endtask

	initial begin : sink
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_beat(out_byte, error, last_of_run, string_done);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (rx_idle_en) begin
				stall_left = draw_gap();
				out_stall <= (stall_left > 0);
				if (stall_left > 0) stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int phase;
		int batch_end;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		code_unit <= '0;
		end_of_string <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// UTF-16: every encoded length, ignored upper bits, pairs at both ends
		check_format_reg();
		send_unit(32'h0000_0000, 1'b0);
		send_unit(32'h0000_007F, 1'b0);
		send_unit(32'h0000_0080, 1'b0);
		send_unit(32'h0000_07FF, 1'b0);
		send_unit(32'h0000_0800, 1'b0);
		send_unit(32'hABCD_FFFF, 1'b1);
		send_unit(32'h0000_D800, 1'b0);
		send_unit(32'h0000_DC00, 1'b0);
		send_unit(32'h0000_DBFF, 1'b0);
		send_unit(32'hFFFF_DFFF, 1'b1);
		// high then a non-low unit, then skip to the end of the string
		send_unit(32'h0000_D812, 1'b0);
		send_unit(32'h0000_0041, 1'b0);
		send_unit(32'h0000_0042, 1'b0);
		send_unit(32'h0000_0043, 1'b1);
		// high surrogate as last unit, lone low as last unit
		send_unit(32'h0000_DABC, 1'b1);
		send_unit(32'h0000_DC05, 1'b1);
		// lone low mid-string, the high at the end is only skipped
		send_unit(32'h0000_DFFF, 1'b0);
		send_unit(32'h0000_D800, 1'b1);
		wait_idle();

		// register index beyond 0 leaves the format alone
		apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
		check_format_reg();
		set_format(w2u8_pkg::FMT_UTF32);
		send_unit(32'h0010_FFFF, 1'b0);
		send_unit(32'h0011_0000, 1'b1);
		send_unit(32'h0000_D800, 1'b1);
		send_unit(32'hFFFF_FFFF, 1'b1);
		send_unit(32'h0001_0000, 1'b0);
		send_unit(32'h0000_007F, 1'b1);
		wait_idle();

		// switch to UTF-32 with a high surrogate still held
		set_format(w2u8_pkg::FMT_UTF16);
		send_unit(32'h0000_D9AB, 1'b0);
		wait_idle();
		set_format(w2u8_pkg::FMT_UTF32);
		send_unit(32'h0000_0041, 1'b1);

		live_units = 0;
		phase = 0;
		while (live_units < RANDOM_UNITS) begin
			wait_idle();
			set_format((phase < 2) ? phase[0] : logic'($urandom_range(0, 1)));
			tx_idle_en = (phase % 4) != 3;
			rx_idle_en = (phase % 5) != 4;
			if (phase == 1) begin
				// fill the block against a stalled output
				tx_idle_en = 1'b0;
				hold_req = 1'b1;
			end
			batch_end = live_units + BATCH_UNITS;
			while (live_units < batch_end)
				send_string();
			phase++;
		end

		wait_idle();
		repeat (16) @(posedge clk);
		if (sb.fails == 0 && sb.pending_bytes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### files.f
src/w2u8_pkg.sv
src/w2u8_front.sv
src/w2u8_queue.sv
src/w2u8_back.sv
src/wide_to_utf8_transcoder_core.sv
tb/tb.sv
